// ----- design/selt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// selt_pkg: shared types and codes of the lock table
// request and response beats, operation and reason codes, controller states
// ----------------------------------------------------------------------------
package selt_pkg;

    localparam int TXN_W = 16;

    // request operations
    localparam logic [1:0] FN_ACQUIRE = 2'd0;
    localparam logic [1:0] FN_RELEASE = 2'd1;
    localparam logic [1:0] FN_QUERY   = 2'd2;

    // failure reasons
    localparam logic [2:0] RSN_NONE       = 3'd0;
    localparam logic [2:0] RSN_CONFLICT   = 3'd1;
    localparam logic [2:0] RSN_UPGRADE    = 3'd2;
    localparam logic [2:0] RSN_FULL       = 3'd3;
    localparam logic [2:0] RSN_NOT_HOLDER = 3'd4;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [1:0]       func;
        logic [TXN_W-1:0] txn;
        logic             want_x;
    } t_req;

    typedef struct packed {
        logic       ok;
        logic [2:0] reason;
        logic       mode_now;
        logic [2:0] holders_now;
        logic [7:0] own_count;
    } t_resp;

endpackage
`default_nettype wire

// ----- design/selt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// selt_ram: lock entry memory
// one write port and one read port, read data registered
// ----------------------------------------------------------------------------
module selt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    parameter int AW    = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- design/selt_update.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// selt_update: lock entry update
// takes the entry read from memory and one request, gives the new entry
// and the response beat
// ----------------------------------------------------------------------------
module selt_update #(
    parameter int HOLDERS   = 4,
    parameter int COUNT_MAX = 255,
    parameter int CW        = 8,
    parameter int RW        = 1 + HOLDERS * (1 + 16 + CW)
) (
    input  wire logic [RW-1:0]     i_row,
    input  wire selt_pkg::t_req    i_req,
    input  wire logic              i_in_range,
    output logic      [RW-1:0]     o_row,
    output selt_pkg::t_resp        o_resp
);
    import selt_pkg::*;

    localparam int SW  = 1 + TXN_W + CW;
    localparam int HIW = (HOLDERS > 1) ? $clog2(HOLDERS) : 1;
    localparam int HCW = $clog2(HOLDERS + 1);

    logic             v    [HOLDERS];
    logic [TXN_W-1:0] t    [HOLDERS];
    logic [CW-1:0]    c    [HOLDERS];
    logic             nv   [HOLDERS];
    logic [TXN_W-1:0] nt   [HOLDERS];
    logic [CW-1:0]    nc   [HOLDERS];
    logic             mode;
    logic             nmode;
    logic             hit;
    logic [HIW-1:0]   h;
    logic             has_free;
    logic [HIW-1:0]   f;
    logic [HCW-1:0]   n_old;
    logic [HCW-1:0]   n_new;
    logic             upgrade;
    logic             granted_new;
    logic [CW-1:0]    rel_cnt;
    logic [31:0]      own_w;
    logic [31:0]      hold_w;

    // unpack and search the entry
    always_comb begin
        mode     = i_row[0];
        hit      = 1'b0;
        h        = '0;
        has_free = 1'b0;
        f        = '0;
        n_old    = '0;
        for (int s = 0; s < HOLDERS; s++) begin
            v[s] = i_row[1 + s*SW];
            t[s] = i_row[2 + s*SW +: TXN_W];
            c[s] = i_row[2 + TXN_W + s*SW +: CW];
            n_old = n_old + HCW'(v[s]);
        end
        // descending scan leaves the lowest matching slot
        for (int s = HOLDERS - 1; s >= 0; s--) begin
            if (v[s] && t[s] == i_req.txn) begin
                hit = 1'b1;
                h   = HIW'(s);
            end
            if (!v[s]) begin
                has_free = 1'b1;
                f        = HIW'(s);
            end
        end
    end

    // apply the request
    always_comb begin
        for (int s = 0; s < HOLDERS; s++) begin
            nv[s] = v[s];
            nt[s] = t[s];
            nc[s] = c[s];
        end
        nmode       = mode;
        upgrade     = !mode && i_req.want_x;
        granted_new = 1'b0;
        rel_cnt     = (c[h] != '0) ? CW'(c[h] - 1'b1) : '0;
        o_resp      = '0;
        o_resp.reason = RSN_NONE;
        case (i_req.func)
            FN_ACQUIRE: begin
                if (hit) begin
                    if (upgrade && n_old != HCW'(1)) begin
                        o_resp.reason = RSN_UPGRADE;
                    end else if (c[h] >= CW'(COUNT_MAX)) begin
                        o_resp.reason = RSN_FULL;
                    end else begin
                        if (upgrade) begin
                            nmode = 1'b1;
                        end
                        nc[h]     = CW'(c[h] + 1'b1);
                        o_resp.ok = 1'b1;
                    end
                end else if (n_old != '0 && (mode || i_req.want_x)) begin
                    o_resp.reason = RSN_CONFLICT;
                end else if (!has_free) begin
                    o_resp.reason = RSN_FULL;
                end else begin
                    nv[f] = 1'b1;
                    nt[f] = i_req.txn;
                    nc[f] = CW'(1);
                    if (n_old == '0) begin
                        nmode = i_req.want_x;
                    end
                    granted_new = 1'b1;
                    o_resp.ok   = 1'b1;
                end
            end
            FN_RELEASE: begin
                if (!hit) begin
                    o_resp.reason = RSN_NOT_HOLDER;
                end else begin
                    nc[h] = rel_cnt;
                    if (rel_cnt == '0) begin
                        nv[h] = 1'b0;
                        if (n_old == HCW'(1)) begin
                            nmode = 1'b0;
                        end
                    end
                    o_resp.ok = 1'b1;
                end
            end
            FN_QUERY: begin
                if (hit) begin
                    o_resp.ok = 1'b1;
                end else begin
                    o_resp.reason = RSN_NOT_HOLDER;
                end
            end
            default: begin
                o_resp.ok = 1'b0;
            end
        endcase

        // pack the new entry
        o_row    = i_row;
        o_row[0] = nmode;
        n_new    = '0;
        for (int s = 0; s < HOLDERS; s++) begin
            o_row[1 + s*SW]              = nv[s];
            o_row[2 + s*SW +: TXN_W]     = nt[s];
            o_row[2 + TXN_W + s*SW +: CW] = nc[s];
            n_new = n_new + HCW'(nv[s]);
        end

        // txn ids are unique within an entry, so the hit slot is the owner
        if (hit) begin
            own_w = 32'(nc[h]);
        end else if (granted_new) begin
            own_w = 32'd1;
        end else begin
            own_w = '0;
        end
        hold_w = 32'(n_new);

        o_resp.mode_now    = nmode;
        o_resp.holders_now = hold_w[2:0];
        o_resp.own_count   = own_w[7:0];

        if (!i_in_range) begin
            o_resp        = '0;
            o_resp.reason = RSN_NOT_HOLDER;
        end
    end

endmodule
`default_nettype wire

// ----- design/shared_exclusive_lock_table_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shared_exclusive_lock_table_top: shared/exclusive reentrant lock table
// one entry per resource with a mode bit and HOLDERS holder slots
// ----------------------------------------------------------------------------
// After reset the block sweeps the entry memory clear, one entry a cycle, over
// all RESOURCES entries (1024 at the default size); busy stays high throughout.
// A request beat is taken at a clock edge with start high and busy low. The
// entry is read from memory in the cycle after the edge, updated and written
// back at the next edge, and the response beat is shown on the o_ ports with
// o_done high for exactly one cycle right after that. busy is high while a
// request is in flight, so a new request is not taken before the last one is
// written back; the next may be taken at the edge that closes the response
// cycle. The receiver cannot stall: a response beat not captured in its o_done
// cycle is gone.
// ----------------------------------------------------------------------------
module shared_exclusive_lock_table_top #(
    parameter int RESOURCES = 1024,
    parameter int HOLDERS   = 4,
    parameter int COUNT_MAX = 255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_func,
    input  wire logic [9:0]  i_resource,
    input  wire logic [15:0] i_txn,
    input  wire logic        i_want_exclusive,
    output logic             o_done,
    output logic             o_ok,
    output logic [2:0]       o_reason,
    output logic             o_mode_now,
    output logic [2:0]       o_holders_now,
    output logic [7:0]       o_own_count
);
    import selt_pkg::*;

    // entry layout: mode bit, then per slot a valid bit, txn id and count
    localparam int AW = $clog2(RESOURCES);
    localparam int CW = $clog2(COUNT_MAX + 1);
    localparam int SW = 1 + TXN_W + CW;
    localparam int RW = 1 + HOLDERS * SW;

    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] r_addr;
    t_req          r_req;
    logic          r_in_range;
    logic          r_done;
    t_resp         r_resp;

    logic          w_accept;
    logic          w_clearing;
    logic          w_clr_last;
    logic          w_mem_we;
    logic [AW-1:0] w_waddr;
    logic [RW-1:0] w_wdata;
    logic [RW-1:0] w_rdata;
    logic [RW-1:0] w_row_new;
    t_resp         w_resp;
    logic [31:0]   w_res_ext;
    logic          w_in_range;

    assign w_accept   = start && !busy;
    assign w_res_ext  = {22'd0, i_resource};
    assign w_in_range = w_res_ext < 32'(RESOURCES);
    assign w_clr_last = (r_clr_addr == AW'(RESOURCES - 1));

    // controller: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (w_clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // controller: outputs
    always_comb begin
        busy       = 1'b1;
        w_clearing = 1'b0;
        w_mem_we   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_clearing = 1'b1;
                w_mem_we   = 1'b1;
            end
            S_IDLE: begin
                busy = 1'b0;
            end
            S_EXEC: begin
                // out-of-range requests leave memory untouched
                w_mem_we = r_in_range;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_EXEC);
            if (w_clearing) begin
                r_clr_addr <= AW'(r_clr_addr + 1'b1);
            end
        end
    end

    // request capture, memory read goes out on the same edge
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.func   <= i_func;
            r_req.txn    <= i_txn;
            r_req.want_x <= i_want_exclusive;
            r_addr       <= w_res_ext[AW-1:0];
            r_in_range   <= w_in_range;
        end
    end

    // response beat register
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_resp <= w_resp;
        end
    end

    // clearing pass writes empty shared entries
    assign w_waddr = w_clearing ? r_clr_addr : r_addr;
    assign w_wdata = w_clearing ? '0 : w_row_new;

    selt_ram #(
        .DEPTH (RESOURCES),
        .WIDTH (RW),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_res_ext[AW-1:0]),
        .o_rdata (w_rdata)
    );

    selt_update #(
        .HOLDERS   (HOLDERS),
        .COUNT_MAX (COUNT_MAX),
        .CW        (CW),
        .RW        (RW)
    ) u_update (
        .i_row      (w_rdata),
        .i_req      (r_req),
        .i_in_range (r_in_range),
        .o_row      (w_row_new),
        .o_resp     (w_resp)
    );

    assign o_done        = r_done;
    assign o_ok          = r_resp.ok;
    assign o_reason      = r_resp.reason;
    assign o_mode_now    = r_resp.mode_now;
    assign o_holders_now = r_resp.holders_now;
    assign o_own_count   = r_resp.own_count;

    // a response beat always follows an execute cycle
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_EXEC))
        else $error("response beat without a request in flight");

    // no request is taken while the clearing pass runs
    a_busy_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> busy)
        else $error("request port open during clearing pass");

    // a granted request carries no failure reason
    a_ok_no_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_ok) |-> (o_reason == RSN_NONE))
        else $error("granted response with failure reason");

    // a taken request yields a response beat after its execute cycle
    a_beat_per_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("request lost");

endmodule
`default_nettype wire
